>>> rtl/svqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svqs_pkg
// Shared types and constants of the sprite quad vertex setup block.
// ----------------------------------------------------------------------------
package svqs_pkg;

	localparam int CORNER_COUNT = 4;
	localparam int Q_DEPTH = 4;
	localparam int SUM_W = 48;
	localparam int PROD_W = 47;
	localparam int RECIP_W = 25;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [3:0] {
		REG_QUAD_WIDTH    = 4'd0,
		REG_QUAD_HEIGHT   = 4'd1,
		REG_ATLAS_ENABLE  = 4'd2,
		REG_ATLAS_COLUMNS = 4'd3,
		REG_ATLAS_ROWS    = 4'd4,
		REG_VERTEX_COLOUR = 4'd5,
		REG_U_RANGE       = 4'd6,
		REG_V_RANGE       = 4'd7
	} cfg_reg_e;

	typedef enum logic [1:0] {
		CORNER_TL = 2'd0,
		CORNER_TR = 2'd1,
		CORNER_BL = 2'd2,
		CORNER_BR = 2'd3
	} corner_e;

	typedef struct packed {
		logic [3:0]  index;
		logic [31:0] data;
	} cfg_req_t;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [15:0]        rotation;
		logic [15:0]        scale_x;
		logic [15:0]        scale_y;
		logic [15:0]        pattern_index;
		logic [7:0]         row_index;
	} sprite_t;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [31:0]        colour;
		logic [1:0]         corner;
		logic               last_corner;
	} vertex_t;

	// Live configuration; column and row counts are stored clamped to 1..256.
	typedef struct packed {
		logic [14:0]        quad_width;
		logic [14:0]        quad_height;
		logic               atlas_enable;
		logic [8:0]         columns;
		logic [8:0]         rows;
		logic [RECIP_W-1:0] col_recip;
		logic [RECIP_W-1:0] row_recip;
		logic [31:0]        vertex_colour;
		logic [31:0]        u_range;
		logic [31:0]        v_range;
	} cfg_vals_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]  xt;
		logic signed [SUM_W-1:0]  xb;
		logic signed [SUM_W-1:0]  yt;
		logic signed [SUM_W-1:0]  yb;
		logic signed [PROD_W-1:0] p1;
		logic signed [PROD_W-1:0] p3;
	} geom_t;

	typedef struct packed {
		geom_t       geom;
		logic [15:0] ul;
		logic [15:0] ur;
		logic [15:0] vt;
		logic [15:0] vb;
	} quad_t;

endpackage
`default_nettype wire

>>> rtl/svqs_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svqs_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface svqs_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/svqs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svqs_cfg
// Configuration registers and the reciprocal unit for the atlas cell counts.
// ----------------------------------------------------------------------------
module svqs_cfg
	import svqs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	svqs_stream_if.sink     cfg,
	output cfg_vals_t       vals,
	output logic            busy
);

	localparam logic [4:0] TOP_BIT = 5'(RECIP_W - 1);

	cfg_vals_t          vals_q;
	logic               busy_q;
	logic               sel_row_q;
	logic [4:0]         cnt_q;
	logic [8:0]         rem_q;
	logic [RECIP_W-1:0] quo_q;
	logic [8:0]         divisor;
	logic [9:0]         rem_next;
	logic               ge;
	logic               wr;

	function automatic logic [8:0] clamp_cells(input logic [8:0] v);
		if (v == 9'd0) begin
			return 9'd1;
		end else if (v[8] && (v[7:0] != 8'd0)) begin
			return 9'd256;
		end
		return v;
	endfunction

	assign wr = cfg.valid && cfg.ready;
	assign cfg.ready = !busy_q;
	assign busy = busy_q;
	assign vals = vals_q;

	// One quotient bit of 2^24 / count per cycle.
	assign divisor = sel_row_q ? vals_q.rows : vals_q.columns;
	assign rem_next = {rem_q, (cnt_q == TOP_BIT)};
	assign ge = rem_next >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vals_q.quad_width <= 15'd1024;
			vals_q.quad_height <= 15'd1024;
			vals_q.atlas_enable <= 1'b0;
			vals_q.columns <= 9'd1;
			vals_q.rows <= 9'd1;
			vals_q.col_recip <= RECIP_W'(1) << (RECIP_W - 1);
			vals_q.row_recip <= RECIP_W'(1) << (RECIP_W - 1);
			vals_q.vertex_colour <= 32'hFFFF_FFFF;
			vals_q.u_range <= 32'h4000_0000;
			vals_q.v_range <= 32'h4000_0000;
			busy_q <= 1'b0;
			sel_row_q <= 1'b0;
			cnt_q <= 5'd0;
			rem_q <= 9'd0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 9'(rem_next - {1'b0, divisor}) : rem_q[8:0] << 1 | 9'(rem_next[0]);
			quo_q <= {quo_q[RECIP_W-2:0], ge};
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				if (sel_row_q) begin
					vals_q.row_recip <= {quo_q[RECIP_W-2:0], ge};
				end else begin
					vals_q.col_recip <= {quo_q[RECIP_W-2:0], ge};
				end
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end else if (wr) begin
			case (cfg_reg_e'(cfg.payload.index))
				REG_QUAD_WIDTH: begin
					vals_q.quad_width <= cfg.payload.data[14:0];
				end
				REG_QUAD_HEIGHT: begin
					vals_q.quad_height <= cfg.payload.data[14:0];
				end
				REG_ATLAS_ENABLE: begin
					vals_q.atlas_enable <= cfg.payload.data[0];
				end
				REG_ATLAS_COLUMNS: begin
					vals_q.columns <= clamp_cells(cfg.payload.data[8:0]);
					sel_row_q <= 1'b0;
					busy_q <= 1'b1;
					cnt_q <= TOP_BIT;
					rem_q <= 9'd0;
				end
				REG_ATLAS_ROWS: begin
					vals_q.rows <= clamp_cells(cfg.payload.data[8:0]);
					sel_row_q <= 1'b1;
					busy_q <= 1'b1;
					cnt_q <= TOP_BIT;
					rem_q <= 9'd0;
				end
				REG_VERTEX_COLOUR: begin
					vals_q.vertex_colour <= cfg.payload.data;
				end
				REG_U_RANGE: begin
					vals_q.u_range <= cfg.payload.data;
				end
				REG_V_RANGE: begin
					vals_q.v_range <= cfg.payload.data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/svqs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svqs_front
// Accepts sprite poses and works out corner geometry terms and atlas or fixed UVs.
// ----------------------------------------------------------------------------
module svqs_front
	import svqs_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
)(
	input  wire logic       clk,
	input  wire logic       arst_n,
	svqs_stream_if.sink     sprite,
	input  cfg_vals_t       cfg,
	input  wire logic       busy,
	svqs_stream_if.source   quads
);

	localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);
	localparam int QUARTER = SINE_TABLE_DEPTH / 4;
	localparam int IDX_W = $clog2(QUARTER + 1);

	typedef logic [14:0] qtab_t [QUARTER+1];

	function automatic qtab_t build_qtab();
		qtab_t             t;
		longint unsigned   f;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint            sum;
		for (int i = 0; i <= QUARTER; i++) begin
			f = (longint'(i) << 30) / QUARTER;
			x = (f * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			term = ((term * x2) >> 30) / 6;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 110;
			sum = sum - longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 32768) >>> 16;
			if (sum > 16384) begin
				sum = 16384;
			end
			t[i] = 15'(sum);
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	function automatic logic [15:0] sat_uv(input logic [23:0] v);
		return (v > 24'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	logic                     en;
	logic                     take;
	logic [LOG_D-1:0]         k;
	logic [1:0]               squad;
	logic [1:0]               cquad;
	logic [IDX_W-1:0]         jw;
	logic [IDX_W-1:0]         sidx;
	logic [IDX_W-1:0]         cidx;

	// Stage 1: captured pose and table lookups.
	logic                     v_s1;
	logic signed [15:0]       ox_s1, oy_s1;
	logic [15:0]              sx_s1, sy_s1, pat_s1;
	logic [7:0]               row_s1;
	logic [14:0]              smag_s1, cmag_s1;
	logic                     sneg_s1, cneg_s1;
	// Stage 2: signed trig, half sizes, centre, reciprocal products.
	logic                     v_s2;
	logic signed [15:0]       sn_s2, cs_s2;
	logic [30:0]              a_s2, b_s2;
	logic signed [43:0]       cx_s2, cy_s2;
	logic [40:0]              pr_s2;
	logic [15:0]              pat_s2;
	logic [33:0]              rtp_s2, rbp_s2;
	logic [7:0]               row_s2;
	// Stage 3: rotated terms, quotient estimates times divisor.
	logic                     v_s3;
	logic signed [PROD_W-1:0] p1_s3, p2_s3, p3_s3, p4_s3;
	logic signed [43:0]       cx_s3, cy_s3;
	logic [24:0]              cqn_s3;
	logic [15:0]              pat_s3;
	logic [23:0]              vte_s3, vbe_s3;
	logic [32:0]              vtp_s3, vbp_s3;
	logic [7:0]               row_s3;
	// Stage 4: partial corner sums, column remainder and row quotients.
	logic                     v_s4;
	geom_t                    g_s4;
	logic [7:0]               col_s4;
	logic [23:0]              vt_s4, vb_s4;
	// Stage 5.
	logic                     v_s5;
	geom_t                    g_s5;
	logic [7:0]               col_s5;
	logic [33:0]              ulp_s5, urp_s5;
	logic [23:0]              vt_s5, vb_s5;
	// Stage 6.
	logic                     v_s6;
	geom_t                    g_s6;
	logic [8:0]               col_s6;
	logic [23:0]              ule_s6, ure_s6;
	logic [32:0]              ulq_s6, urq_s6;
	logic [23:0]              vt_s6, vb_s6;
	// Stage 7: finished quad.
	logic                     v_s7;
	quad_t                    q_s7;

	logic signed [17:0]       cxs, cys;
	logic [24:0]              crem;
	logic [9:0]               crem10;
	logic [32:0]              rt, rb;
	logic [32:0]              rl, rr;
	logic [23:0]              ul_fin, ur_fin;

	assign en = !v_s7 || quads.ready;
	assign sprite.ready = en && !busy;
	assign take = sprite.valid && sprite.ready;
	assign quads.valid = v_s7;
	assign quads.payload = q_s7;

	// Table index from the angle; cosine is the sine one quadrant ahead.
	assign k = sprite.payload.rotation[15 -: LOG_D];
	assign squad = k[LOG_D-1 -: 2];
	assign cquad = squad + 2'd1;
	assign jw = IDX_W'(k[LOG_D-3:0]);
	assign sidx = squad[0] ? IDX_W'(QUARTER) - jw : jw;
	assign cidx = cquad[0] ? IDX_W'(QUARTER) - jw : jw;

	assign cxs = $signed({ox_s1[15], ox_s1, 1'b0}) + $signed({3'b000, cfg.quad_width});
	assign cys = $signed({oy_s1[15], oy_s1, 1'b0}) + $signed({3'b000, cfg.quad_height});

	assign crem = {9'd0, pat_s3} - cqn_s3;
	assign crem10 = crem[9:0];
	assign rt = {11'd0, row_s3, 14'd0} - vtp_s3;
	assign rb = {10'd0, ({1'b0, row_s3} + 9'd1), 14'd0} - vbp_s3;
	assign rl = {10'd0, col_s6, 14'd0} - ulq_s6;
	assign rr = {10'd0, (col_s6 + 9'd1), 14'd0} - urq_s6;
	assign ul_fin = ule_s6 + 24'(rl[9:0] >= {1'b0, cfg.columns});
	assign ur_fin = ure_s6 + 24'(rr[9:0] >= {1'b0, cfg.columns});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s1 <= sprite.payload.origin_x;
			oy_s1 <= sprite.payload.origin_y;
			sx_s1 <= sprite.payload.scale_x;
			sy_s1 <= sprite.payload.scale_y;
			pat_s1 <= sprite.payload.pattern_index;
			row_s1 <= sprite.payload.row_index;
			smag_s1 <= QTAB[sidx];
			cmag_s1 <= QTAB[cidx];
			sneg_s1 <= squad[1];
			cneg_s1 <= cquad[1];

			sn_s2 <= sneg_s1 ? -$signed({1'b0, smag_s1}) : $signed({1'b0, smag_s1});
			cs_s2 <= cneg_s1 ? -$signed({1'b0, cmag_s1}) : $signed({1'b0, cmag_s1});
			a_s2 <= {16'd0, cfg.quad_width} * {15'd0, sx_s1};
			b_s2 <= {16'd0, cfg.quad_height} * {15'd0, sy_s1};
			cx_s2 <= {cxs, 26'd0};
			cy_s2 <= {cys, 26'd0};
			pr_s2 <= {25'd0, pat_s1} * {16'd0, cfg.col_recip};
			pat_s2 <= pat_s1;
			rtp_s2 <= {26'd0, row_s1} * {9'd0, cfg.row_recip};
			rbp_s2 <= {25'd0, ({1'b0, row_s1} + 9'd1)} * {9'd0, cfg.row_recip};
			row_s2 <= row_s1;

			p1_s3 <= $signed({1'b0, a_s2}) * cs_s2;
			p2_s3 <= $signed({1'b0, b_s2}) * sn_s2;
			p3_s3 <= $signed({1'b0, a_s2}) * sn_s2;
			p4_s3 <= $signed({1'b0, b_s2}) * cs_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			cqn_s3 <= {9'd0, pr_s2[39:24]} * {16'd0, cfg.columns};
			pat_s3 <= pat_s2;
			vte_s3 <= rtp_s2[33:10];
			vbe_s3 <= rbp_s2[33:10];
			vtp_s3 <= {9'd0, rtp_s2[33:10]} * {24'd0, cfg.rows};
			vbp_s3 <= {9'd0, rbp_s2[33:10]} * {24'd0, cfg.rows};
			row_s3 <= row_s2;

			// Top corners subtract dy*sin with dy negative, bottom ones with dy positive.
			g_s4.xt <= SUM_W'(cx_s3) + SUM_W'(p2_s3);
			g_s4.xb <= SUM_W'(cx_s3) - SUM_W'(p2_s3);
			g_s4.yt <= SUM_W'(cy_s3) - SUM_W'(p4_s3);
			g_s4.yb <= SUM_W'(cy_s3) + SUM_W'(p4_s3);
			g_s4.p1 <= p1_s3;
			g_s4.p3 <= p3_s3;
			col_s4 <= (crem10 >= {1'b0, cfg.columns}) ?
				8'(crem10 - {1'b0, cfg.columns}) : crem10[7:0];
			vt_s4 <= vte_s3 + 24'(rt[9:0] >= {1'b0, cfg.rows});
			vb_s4 <= vbe_s3 + 24'(rb[9:0] >= {1'b0, cfg.rows});

			g_s5 <= g_s4;
			col_s5 <= col_s4;
			ulp_s5 <= {26'd0, col_s4} * {9'd0, cfg.col_recip};
			urp_s5 <= {25'd0, ({1'b0, col_s4} + 9'd1)} * {9'd0, cfg.col_recip};
			vt_s5 <= vt_s4;
			vb_s5 <= vb_s4;

			g_s6 <= g_s5;
			col_s6 <= {1'b0, col_s5};
			ule_s6 <= ulp_s5[33:10];
			ure_s6 <= urp_s5[33:10];
			ulq_s6 <= {9'd0, ulp_s5[33:10]} * {24'd0, cfg.columns};
			urq_s6 <= {9'd0, urp_s5[33:10]} * {24'd0, cfg.columns};
			vt_s6 <= vt_s5;
			vb_s6 <= vb_s5;

			q_s7.geom <= g_s6;
			if (cfg.atlas_enable) begin
				q_s7.ul <= sat_uv(ul_fin);
				q_s7.ur <= sat_uv(ur_fin);
				q_s7.vt <= sat_uv(vt_s6);
				q_s7.vb <= sat_uv(vb_s6);
			end else begin
				q_s7.ul <= cfg.u_range[15:0];
				q_s7.ur <= cfg.u_range[31:16];
				q_s7.vt <= cfg.v_range[15:0];
				q_s7.vb <= cfg.v_range[31:16];
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/svqs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svqs_fifo
// Short queue of prepared quads between the front and the back part.
// ----------------------------------------------------------------------------
module svqs_fifo
	import svqs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	svqs_stream_if.sink     wr,
	svqs_stream_if.source   rd
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	quad_t            mem [Q_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0]   cnt_q;
	logic             push, pop;

	assign wr.ready = cnt_q != (PTR_W+1)'(Q_DEPTH);
	assign rd.valid = cnt_q != '0;
	assign rd.payload = mem[rp_q];
	assign push = wr.valid && wr.ready;
	assign pop = rd.valid && rd.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/svqs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svqs_back
// Registers each queued quad's four corners, one vertex a cycle unless held.
// ----------------------------------------------------------------------------
module svqs_back
	import svqs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	svqs_stream_if.sink     quads,
	input  cfg_vals_t       cfg,
	svqs_stream_if.source   vertex
);

	function automatic logic signed [15:0] round_sat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t;
		logic signed [20:0]      v;
		t = s + (SUM_W'(1) <<< 26);
		v = 21'(t >>> 27);
		if (v > 21'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -21'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	logic [1:0]              ctr_q;
	logic                    ovalid_q;
	vertex_t                 out_q;
	logic                    load;
	logic                    right, bottom;
	logic signed [SUM_W-1:0] x, y;
	geom_t                   g;

	assign g = quads.payload.geom;
	assign right = ctr_q[0];
	assign bottom = ctr_q[1];
	assign load = quads.valid && (!ovalid_q || vertex.ready);
	assign quads.ready = load && (corner_e'(ctr_q) == CORNER_BR);
	assign vertex.valid = ovalid_q;
	assign vertex.payload = out_q;

	assign x = (bottom ? g.xb : g.xt) + (right ? SUM_W'(g.p1) : -SUM_W'(g.p1));
	assign y = (bottom ? g.yb : g.yt) + (right ? SUM_W'(g.p3) : -SUM_W'(g.p3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ctr_q <= ctr_q + 2'd1;
				ovalid_q <= 1'b1;
			end else if (vertex.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.vertex_x <= round_sat(x);
			out_q.vertex_y <= round_sat(y);
			out_q.tex_u <= right ? quads.payload.ur : quads.payload.ul;
			out_q.tex_v <= bottom ? quads.payload.vb : quads.payload.vt;
			out_q.colour <= cfg.vertex_colour;
			out_q.corner <= ctr_q;
			out_q.last_corner <= corner_e'(ctr_q) == CORNER_BR;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sprite_quad_vertex_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup
// Turns a sprite pose into four rotated, scaled corner vertices with UVs.
// ----------------------------------------------------------------------------
// Use: send one request per sprite on "sprite" (valid/ready). Four vertex
// requests leave on "vertex" in the order top-left, top-right, bottom-left,
// bottom-right; the last one carries last_corner.
// Configuration: write registers on "cfg" (index 0..7) while no sprite is
// in flight. A write of atlas columns or rows starts a reciprocal
// computation; cfg and sprite ready stay low during it.
// Path: a sprite passes the 7-stage front pipeline, the quad queue and
// the vertex register before its first vertex is valid.
// Throughput: one vertex per cycle while vertex ready stays high, set by
// the back part that emits the corners one at a time.
// Stall: when the receiver holds vertex ready low, the vertex register
// holds, the quad queue fills, and then the front pipeline freezes and
// sprite ready drops. Nothing is lost.
// Reset: control and config registers reset at once, data registers do not;
// the block accepts sprites right after reset.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup
	import svqs_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
)(
	input  wire logic       clk,
	input  wire logic       arst_n,
	svqs_stream_if.sink     sprite,
	svqs_stream_if.source   vertex,
	svqs_stream_if.sink     cfg
);

	cfg_vals_t vals;
	logic      busy;

	// Queue between front and back: each side stalls on its own.
	svqs_stream_if #(.payload_t(quad_t)) quad_in ();
	svqs_stream_if #(.payload_t(quad_t)) quad_out ();

	// Hold registers and recompute reciprocals of the cell counts.
	svqs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.vals   (vals),
		.busy   (busy)
	);

	// Advance poses through trig lookup, products and atlas divisions.
	svqs_front #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sprite (sprite),
		.cfg    (vals),
		.busy   (busy),
		.quads  (quad_in)
	);

	svqs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (quad_in),
		.rd     (quad_out)
	);

	// Drop each quad from the queue once its fourth corner is registered.
	svqs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.quads  (quad_out),
		.cfg    (vals),
		.vertex (vertex)
	);

endmodule
`default_nettype wire

>>> test/svqs_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svqs_vertex_checker
// Watches the sprite, config and vertex channels of the quad setup block,
// predicts the four corner vertices of every accepted sprite and compares.
// ----------------------------------------------------------------------------
module svqs_vertex_checker
	import svqs_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic sprite_valid,
	input  wire logic sprite_ready,
	input  sprite_t   sprite_data,
	input  wire logic cfg_valid,
	input  wire logic cfg_ready,
	input  cfg_req_t  cfg_data,
	input  wire logic vertex_valid,
	input  wire logic vertex_ready,
	input  vertex_t   vertex_data,
	output int        fail_count,
	output int        vertices_due,
	output int        vertices_seen
);

	logic [14:0] width_q, height_q;
	logic        atlas_on;
	logic [8:0]  columns_q, rows_q;
	logic [31:0] colour_q, u_range_q, v_range_q;

	vertex_t due_vertices[$];

	// Quarter-wave sine: f in Q30 of a quarter turn, result Q14 in [0, 16384].
	function automatic longint quarter_wave(longint unsigned f);
		longint unsigned x, x2, term;
		longint sum;
		x = (f * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) sum -= longint'(term);
			else sum += longint'(term);
		end
		if (sum < 0) sum = 0;
		sum = (sum + 32768) >>> 16;
		if (sum > 16384) sum = 16384;
		return sum;
	endfunction

	function automatic longint phase_sine(logic [31:0] ph);
		longint s;
		if (ph[30]) s = quarter_wave((64'd1 << 30) - 64'(ph[29:0]));
		else s = quarter_wave(64'(ph[29:0]));
		return ph[31] ? -s : s;
	endfunction

	// Round half up from Q.31 to Q12.4, then saturate.
	function automatic logic [15:0] round_position(longint v);
		longint t;
		t = (v + (longint'(1) << 26)) >>> 27;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t[15:0];
	endfunction

	function automatic longint unsigned cells(logic [8:0] c);
		if (c == 0) return 1;
		return (c > 256) ? 256 : c;
	endfunction

	function automatic logic [15:0] uv_sat(longint unsigned v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	task automatic predict_corners(sprite_t s);
		longint unsigned k, nc, nr, col, row;
		logic [31:0] ph;
		longint sn, cs, ox, oy, w, h, cx, cy, dx, dy;
		logic [15:0] ul, ur, vt, vb;
		vertex_t vx;
		k = (longint'(s.rotation) * SINE_TABLE_DEPTH) >> 16;
		ph = (k << 32) / SINE_TABLE_DEPTH;
		sn = phase_sine(ph);
		cs = phase_sine(ph + 32'h4000_0000);
		ox = $signed(s.origin_x);
		oy = $signed(s.origin_y);
		w = width_q;
		h = height_q;
		cx = (2 * ox + w) * (longint'(1) << 26);
		cy = (2 * oy + h) * (longint'(1) << 26);
		if (atlas_on) begin
			nc = cells(columns_q);
			nr = cells(rows_q);
			col = s.pattern_index % nc;
			row = s.row_index;
			ul = uv_sat((col * 16384) / nc);
			ur = uv_sat(((col + 1) * 16384) / nc);
			vt = uv_sat((row * 16384) / nr);
			vb = uv_sat(((row + 1) * 16384) / nr);
		end else begin
			ul = u_range_q[15:0];
			ur = u_range_q[31:16];
			vt = v_range_q[15:0];
			vb = v_range_q[31:16];
		end
		for (int c = 0; c < CORNER_COUNT; c++) begin
			dx = (c[0] ? w : -w) * longint'(s.scale_x);
			dy = (c[1] ? h : -h) * longint'(s.scale_y);
			vx.vertex_x = round_position(cx + dx * cs - dy * sn);
			vx.vertex_y = round_position(cy + dx * sn + dy * cs);
			vx.tex_u = c[0] ? ur : ul;
			vx.tex_v = c[1] ? vb : vt;
			vx.colour = colour_q;
			vx.corner = c[1:0];
			vx.last_corner = (c == CORNER_COUNT - 1);
			due_vertices.push_back(vx);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: vertex %s mismatch: got %0h, expected %0h", $realtime, what, got,
			want);
		fail_count++;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 15'd1024;
			height_q <= 15'd1024;
			atlas_on <= 1'b0;
			columns_q <= 9'd1;
			rows_q <= 9'd1;
			colour_q <= 32'hFFFF_FFFF;
			u_range_q <= 32'h4000_0000;
			v_range_q <= 32'h4000_0000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_e'(cfg_data.index))
				REG_QUAD_WIDTH:    width_q <= cfg_data.data[14:0];
				REG_QUAD_HEIGHT:   height_q <= cfg_data.data[14:0];
				REG_ATLAS_ENABLE:  atlas_on <= cfg_data.data[0];
				REG_ATLAS_COLUMNS: columns_q <= cfg_data.data[8:0];
				REG_ATLAS_ROWS:    rows_q <= cfg_data.data[8:0];
				REG_VERTEX_COLOUR: colour_q <= cfg_data.data;
				REG_U_RANGE:       u_range_q <= cfg_data.data;
				REG_V_RANGE:       v_range_q <= cfg_data.data;
				default: ;
			endcase
		end
	end

	// The counters are two-state and start at zero.
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && vertex_valid && vertex_ready) begin
			vertices_seen++;
			if (due_vertices.size() == 0) begin
				$display("%0t: vertex with no sprite behind it", $realtime);
				fail_count++;
			end else begin
				want = due_vertices.pop_front();
				if (vertex_data.vertex_x !== want.vertex_x)
					report_mismatch("x", vertex_data.vertex_x, want.vertex_x);
				if (vertex_data.vertex_y !== want.vertex_y)
					report_mismatch("y", vertex_data.vertex_y, want.vertex_y);
				if (vertex_data.tex_u !== want.tex_u)
					report_mismatch("u", vertex_data.tex_u, want.tex_u);
				if (vertex_data.tex_v !== want.tex_v)
					report_mismatch("v", vertex_data.tex_v, want.tex_v);
				if (vertex_data.colour !== want.colour)
					report_mismatch("colour", vertex_data.colour, want.colour);
				if (vertex_data.corner !== want.corner)
					report_mismatch("corner", vertex_data.corner, want.corner);
				if (vertex_data.last_corner !== want.last_corner)
					report_mismatch("last", vertex_data.last_corner, want.last_corner);
			end
		end
		// Config is sampled before its own update this edge, as the block sees it.
		if (arst_n && sprite_valid && sprite_ready)
			predict_corners(sprite_data);
		vertices_due = due_vertices.size();
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the sprite quad vertex setup bench: drives sprites and config
// writes with random idling and stalls; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
	import svqs_pkg::*;

	logic clk;
	logic arst_n;

	svqs_stream_if #(.payload_t(sprite_t))  sprite_ch();
	svqs_stream_if #(.payload_t(vertex_t))  vertex_ch();
	svqs_stream_if #(.payload_t(cfg_req_t)) cfg_ch();

	int fail_count, vertices_due, vertices_seen;
	int sprites_sent;
	int settings_done;
	bit calm;        // no idling on either side in the closing phase
	bit long_hold;   // ask the receiver for one long stall

	sprite_quad_vertex_setup uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sprite (sprite_ch),
		.vertex (vertex_ch),
		.cfg    (cfg_ch)
	);

	svqs_vertex_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.sprite_valid (sprite_ch.valid),
		.sprite_ready (sprite_ch.ready),
		.sprite_data  (sprite_ch.payload),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_data     (cfg_ch.payload),
		.vertex_valid (vertex_ch.valid),
		.vertex_ready (vertex_ch.ready),
		.vertex_data  (vertex_ch.payload),
		.fail_count   (fail_count),
		.vertices_due (vertices_due),
		.vertices_seen(vertices_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#20ms;
		$display("Timeout waiting on the block");
		$display("Some tests failed");
		$finish;
	end

	// Offer one sprite request, maybe after an idle burst; return once accepted.
	// Valid stays high between back-to-back requests.
	task automatic send_sprite(sprite_t s);
		if (!calm && $urandom_range(0, 4) == 0) begin
			sprite_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sprite_ch.valid <= 1'b1;
		sprite_ch.payload <= s;
		do @(posedge clk); while (!sprite_ch.ready);
		sprites_sent++;
	endtask

	// Drop valid and wait until every predicted vertex has drained.
	task automatic drain;
		sprite_ch.valid <= 1'b0;
		@(posedge clk);
		while (vertices_due != 0) @(posedge clk);
		// Allow for the front pipeline to settle as well.
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= '{index: idx, data: value};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write all eight registers; phases 0 and 1 hit the extremes.
	task automatic apply_setting(int phase);
		logic [31:0] w, h, cols, rows;
		w = $urandom_range(0, 32767);
		h = $urandom_range(0, 32767);
		cols = $urandom_range(0, 511);
		rows = $urandom_range(0, 511);
		if (phase == 0) begin
			w = 32767; h = 32767; cols = 511; rows = 0;
		end else if (phase == 1) begin
			w = 0; h = 0; cols = 1; rows = 256;
		end else if (phase == 2) begin
			cols = 256; rows = 1;
			w = $urandom_range(0, 2048); h = $urandom_range(0, 2048);
		end
		write_reg(REG_QUAD_WIDTH, w);
		write_reg(REG_QUAD_HEIGHT, h);
		// Alternate between atlas and fixed UVs; the odd phases and phase 0 use the atlas.
		write_reg(REG_ATLAS_ENABLE, (phase % 2 == 1 || phase == 0) ? 32'd1 : 32'd0);
		write_reg(REG_ATLAS_COLUMNS, cols);
		write_reg(REG_ATLAS_ROWS, rows);
		write_reg(REG_VERTEX_COLOUR, (phase == 0) ? 32'h0 : $urandom());
		write_reg(REG_U_RANGE, (phase == 0) ? 32'hFFFF_FFFF : $urandom());
		write_reg(REG_V_RANGE, (phase == 1) ? 32'h0 : $urandom());
		settings_done++;
	endtask

	function automatic sprite_t random_sprite();
		sprite_t s;
		s.origin_x = 16'($urandom());
		s.origin_y = 16'($urandom());
		s.rotation = 16'($urandom());
		s.pattern_index = 16'($urandom());
		s.row_index = 8'($urandom());
		// Mostly moderate scales, sometimes anything up to full range.
		if ($urandom_range(0, 2) == 0) begin
			s.scale_x = 16'($urandom());
			s.scale_y = 16'($urandom());
		end else begin
			s.scale_x = 16'($urandom_range(0, 16'h2000));
			s.scale_y = 16'($urandom_range(0, 16'h2000));
		end
		// Keep the origin near the screen now and then so positions do not saturate.
		if ($urandom_range(0, 1) == 0) begin
			s.origin_x = 16'($urandom_range(0, 8000));
			s.origin_y = 16'($urandom_range(0, 8000));
		end
		return s;
	endfunction

	// Receiver: random stall bursts, one long hold on request, none when calm.
	initial begin
		bit held;
		held = 1'b0;
		vertex_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold && !held) begin
				vertex_ch.ready <= 1'b0;
				repeat (120) @(posedge clk);
				held = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				vertex_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			vertex_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	initial begin
		sprite_t s;
		int rot_marks[5];
		sprites_sent = 0;
		settings_done = 0;
		calm = 1'b0;
		sprite_ch.valid = 1'b0;
		sprite_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sprites at reset settings: quarter-turn angles and field extremes.
		rot_marks = '{0, 16384, 32768, 49152, 65535};
		foreach (rot_marks[i]) begin
			s = '{origin_x: 16'sd100, origin_y: 16'sd200, rotation: 16'(rot_marks[i]),
				scale_x: 16'h1000, scale_y: 16'h1000, pattern_index: 16'd0,
				row_index: 8'd0};
			send_sprite(s);
		end
		send_sprite('{16'sh7FFF, 16'sh7FFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF});
		send_sprite('{-16'sd32768, -16'sd32768, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'd0});
		send_sprite('{16'sd0, 16'sd0, 16'd8192, 16'd0, 16'd0, 16'd0, 8'd0});
		send_sprite('{-16'sd32768, 16'sh7FFF, 16'd40000, 16'hFFFF, 16'd0, 16'hFFFF, 8'hFF});
		send_sprite('{16'sh7FFF, -16'sd32768, 16'd24000, 16'd0, 16'hFFFF, 16'h5555, 8'hAA});

		// Eight settings with 60 random sprites each.
		for (int phase = 0; phase < 8; phase++) begin
			drain();
			apply_setting(phase);
			// Directed atlas corner cases: last column, row beyond the atlas.
			if (phase < 2) begin
				send_sprite('{16'sd64, 16'sd64, 16'd0, 16'h1000, 16'h1000, 16'hFFFF, 8'hFF});
				send_sprite('{16'sd64, 16'sd64, 16'd0, 16'h1000, 16'h1000, 16'd255, 8'd0});
			end
			if (phase == 7) calm = 1'b1;
			for (int i = 0; i < 60; i++) begin
				// Hold the receiver off long enough to back the block up.
				if (phase == 2 && i == 10) long_hold = 1'b1;
				// Pause the sender until everything in flight has come out.
				if (phase == 4 && i == 30) drain();
				send_sprite(random_sprite());
			end
		end

		drain();
		$display("Covered %0d sprites and %0d vertices over %0d register settings,",
			sprites_sent, vertices_seen, settings_done);
		$display("with stalls on both sides, a long back-pressure hold and a full drain.");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/svqs_pkg.sv
rtl/svqs_stream_if.sv
rtl/svqs_cfg.sv
rtl/svqs_front.sv
rtl/svqs_fifo.sv
rtl/svqs_back.sv
rtl/sprite_quad_vertex_setup.sv
test/svqs_vertex_checker.sv
test/tb.sv
